// ----- hw/rtl/ssa_pkg.sv -----
// Shared types and codes for the scratch slot allocator.
package ssa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC       = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_ADD_PAGE    = 2'd2,
        OP_RELEASE_ALL = 2'd3
    } ssa_op_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NO_SLOT    = 2'd1,
        STAT_NO_PAGE    = 2'd2,
        STAT_STORE_FULL = 2'd3
    } ssa_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_DIVIDE,
        S_DONE
    } ssa_state_t;

    typedef struct packed {
        logic load;
        logic walk_dec;
        logic read_slot;
        logic calc_grant;
        logic div_start;
        logic div_step;
        logic commit;
    } ssa_cmd_t;

    typedef struct packed {
        ssa_op_t op;
        logic    empty;
        logic    walk_last;
        logic    alloc_hit;
        logic    release_hit;
        logic    out_free;
    } ssa_stat_t;

endpackage

// ----- hw/rtl/scratch_slot_allocator_unit.sv -----
// Scratch slot allocator: pages of fixed-size slots, each page with a FIFO of free indices.
// Alloc and release walk the pages newest first; a hit then reads the slot (alloc) or divides
// the offset (release) before the result registers; with no pages, add page, release all go direct.
// One item at a time: the next transfer is taken in the cycle after the result registers, even
// while that result waits; a stalled output holds the following item in its last step.
// Reset clears page count, FIFO pointers and refill flag; bases and slots need no clearing.
module scratch_slot_allocator_unit #(
    parameter int SLOT_BYTES = 64,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] address,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] slot_address,
    output logic [1:0]  status,
    output logic        refill_request,
    output logic [8:0]  free_total
);
    import ssa_pkg::*;

    ssa_cmd_t  cmd;
    ssa_stat_t stat;

    ssa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ssa_dpath #(
        .SLOT_BYTES (SLOT_BYTES),
        .PAGE_BYTES (PAGE_BYTES),
        .MAX_PAGES  (MAX_PAGES)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .opcode         (opcode),
        .address        (address),
        .cmd            (cmd),
        .stat           (stat),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .slot_address   (slot_address),
        .status         (status),
        .refill_request (refill_request),
        .free_total     (free_total)
    );

endmodule

// ----- hw/rtl/ssa_ctrl.sv -----
// Sequencer for the scratch slot allocator: page walk, slot read, divide and commit.
module ssa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        opcode,
    output logic              in_ready,
    input  ssa_pkg::ssa_stat_t stat,
    output ssa_pkg::ssa_cmd_t  cmd
);
    import ssa_pkg::*;

    ssa_state_t state_reg;
    ssa_state_t state_next;
    ssa_op_t    in_op;

    assign in_op = ssa_op_t'(opcode);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    // Alloc and release walk the pages unless there are none.
                    if ((in_op inside {OP_ALLOC, OP_RELEASE}) && !stat.empty)
                    begin
                        state_next = S_SEARCH;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SEARCH:
            begin
                if (stat.op == OP_ALLOC && stat.alloc_hit)
                begin
                    cmd.read_slot = 1'b1;
                    state_next    = S_READ;
                end
                else if (stat.op == OP_RELEASE && stat.release_hit)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.walk_dec = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.calc_grant = 1'b1;
                state_next     = S_DONE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/ssa_dpath.sv -----
// Datapath of the scratch slot allocator: page table, slot FIFO memory and result register.
module ssa_dpath #(
    parameter int SLOT_BYTES = 64,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         opcode,
    input  logic [63:0]        address,
    input  ssa_pkg::ssa_cmd_t  cmd,
    output ssa_pkg::ssa_stat_t stat,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [63:0]        slot_address,
    output logic [1:0]         status,
    output logic               refill_request,
    output logic [8:0]         free_total
);
    import ssa_pkg::*;

    localparam int SLOTS     = PAGE_BYTES / SLOT_BYTES;
    localparam int SLOTS_D   = (SLOTS > 0) ? SLOTS : 1;
    localparam int HALF      = SLOTS / 2;
    localparam int IDX_W     = (SLOTS_D > 1) ? $clog2(SLOTS_D) : 1;
    localparam int CNT_W     = $clog2(SLOTS_D + 1);
    localparam int PG_W      = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W    = $clog2(MAX_PAGES + 1);
    localparam int MEM_DEPTH = MAX_PAGES * SLOTS_D;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int TOT_W     = $clog2(MAX_PAGES * SLOTS_D + 1);
    localparam int SPAN_I    = SLOTS * SLOT_BYTES;
    localparam int SPAN_D    = (SPAN_I > 1) ? SPAN_I : 2;
    localparam int OFF_W     = $clog2(SPAN_D);
    localparam int REC_SH    = OFF_W + $clog2(SLOT_BYTES);
    localparam int REC_W     = OFF_W + 2;
    localparam int MUL_W     = OFF_W + REC_W;
    localparam int SB_W      = $clog2(SLOT_BYTES + 1);
    localparam int PROD_W    = IDX_W + SB_W;
    localparam logic [63:0]      SPAN  = 64'(SLOTS) * 64'(SLOT_BYTES);
    localparam logic [REC_W-1:0] REC_M = REC_W'(((64'd1 << REC_SH) + 64'(SLOT_BYTES) - 64'd1)
                                                / 64'(SLOT_BYTES));

    // Page table and per-page FIFO pointers.
    logic [63:0]      base_reg  [MAX_PAGES];
    logic [IDX_W-1:0] head_reg  [MAX_PAGES];
    logic [CNT_W-1:0] count_reg [MAX_PAGES];
    // Pushes since the page was added, saturating at a full page. Pushes land at
    // FIFO positions 0, 1, 2, ... in order, so a position below this mark holds a
    // pushed index and one above it still holds its own number from the fill.
    logic [CNT_W-1:0] wmark_reg [MAX_PAGES];
    logic [IDX_W-1:0] slot_mem  [MEM_DEPTH];

    logic [PCNT_W-1:0] page_count_reg;
    logic [PCNT_W-1:0] page_count_next;
    logic              pending_reg;
    logic              pending_next;
    logic [TOT_W-1:0]  total_reg;
    logic [TOT_W-1:0]  total_next;
    logic [TOT_W-1:0]  total_dec;

    ssa_op_t           op_reg;
    logic [63:0]       addr_reg;
    logic [PG_W-1:0]   k_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  rdata_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [IDX_W-1:0]  quot_reg;

    logic              out_valid_reg;
    logic [63:0]       slot_address_reg;
    ssa_status_t       status_reg;
    logic              refill_reg;
    logic [8:0]        free_total_reg;

    logic [63:0]       cur_base;
    logic [IDX_W-1:0]  cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  cur_wmark;
    logic [63:0]       offset;
    logic [IDX_W-1:0]  head_inc;
    logic [CNT_W:0]    tail_sum;
    logic [CNT_W:0]    tail_wrap;
    logic [IDX_W-1:0]  tail_pos;
    logic              push_ok;
    logic              store_full;
    logic [PG_W-1:0]   new_pg;
    logic [IDX_W-1:0]  slot_idx;
    logic [MUL_W-1:0]  mul_full;
    logic              out_free;
    logic              mem_we;
    logic [MEM_AW-1:0] rd_addr;
    logic [MEM_AW-1:0] wr_addr;
    logic [63:0]       grant_next;
    ssa_status_t       status_next;
    logic              refill_next;

    function automatic logic [MEM_AW-1:0] slot_addr(input logic [PG_W-1:0] pg,
                                                    input logic [IDX_W-1:0] pos);
        return MEM_AW'(pg) * MEM_AW'(SLOTS_D) + MEM_AW'(pos);
    endfunction

    always_comb
    begin
        cur_base   = base_reg[k_reg];
        cur_head   = head_reg[k_reg];
        cur_count  = count_reg[k_reg];
        cur_wmark  = wmark_reg[k_reg];
        offset     = addr_reg - cur_base;
        head_inc   = (cur_head == IDX_W'(SLOTS_D - 1)) ? '0 : cur_head + 1'b1;
        tail_sum   = (CNT_W + 1)'(cur_head) + (CNT_W + 1)'(cur_count);
        tail_wrap  = (tail_sum >= (CNT_W + 1)'(SLOTS)) ? tail_sum - (CNT_W + 1)'(SLOTS)
                                                       : tail_sum;
        tail_pos   = IDX_W'(tail_wrap);
        push_ok    = cur_count < CNT_W'(SLOTS);
        store_full = page_count_reg == PCNT_W'(MAX_PAGES);
        new_pg     = PG_W'(page_count_reg);
        slot_idx   = (CNT_W'(cur_head) < cur_wmark) ? rdata_reg : cur_head;
        mul_full   = MUL_W'(off_reg) * MUL_W'(REC_M);
        out_free   = !out_valid_reg || out_ready;
        rd_addr    = slot_addr(k_reg, cur_head);
        wr_addr    = slot_addr(k_reg, tail_pos);
        total_dec  = total_reg - 1'b1;
    end

    assign stat.op          = op_reg;
    assign stat.empty       = page_count_reg == '0;
    assign stat.walk_last   = k_reg == '0;
    assign stat.alloc_hit   = cur_count != '0;
    assign stat.release_hit = offset < SPAN;
    assign stat.out_free    = out_free;

    // Result and next state of the item being committed.
    always_comb
    begin
        grant_next      = '0;
        status_next     = STAT_OK;
        refill_next     = 1'b0;
        pending_next    = pending_reg;
        page_count_next = page_count_reg;
        total_next      = total_reg;
        mem_we          = 1'b0;
        case (op_reg)
            OP_ALLOC:
            begin
                if (hit_reg)
                begin
                    grant_next = cur_base + 64'(prod_reg);
                    total_next = total_dec;
                    if (total_dec < TOT_W'(HALF) && !pending_reg)
                    begin
                        refill_next  = 1'b1;
                        pending_next = 1'b1;
                    end
                end
                else
                begin
                    status_next = STAT_NO_SLOT;
                end
            end
            OP_RELEASE:
            begin
                if (hit_reg)
                begin
                    // A push into a full FIFO is dropped but still reports success.
                    if (push_ok)
                    begin
                        total_next = total_reg + 1'b1;
                        mem_we     = cmd.commit;
                    end
                end
                else
                begin
                    status_next = STAT_NO_PAGE;
                end
            end
            OP_ADD_PAGE:
            begin
                pending_next = 1'b0;
                if (store_full)
                begin
                    status_next = STAT_STORE_FULL;
                end
                else
                begin
                    page_count_next = page_count_reg + 1'b1;
                    total_next      = total_reg + TOT_W'(SLOTS);
                end
            end
            OP_RELEASE_ALL:
            begin
                page_count_next = '0;
                total_next      = '0;
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg <= '0;
            pending_reg    <= 1'b0;
            total_reg      <= '0;
            k_reg          <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
                wmark_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load)
            begin
                k_reg   <= PG_W'(page_count_reg - 1'b1);
                hit_reg <= 1'b0;
            end
            if (cmd.walk_dec)
            begin
                k_reg <= k_reg - 1'b1;
            end
            if (cmd.read_slot || cmd.div_start)
            begin
                hit_reg <= 1'b1;
            end

            if (cmd.commit)
            begin
                out_valid_reg  <= 1'b1;
                page_count_reg <= page_count_next;
                pending_reg    <= pending_next;
                total_reg      <= total_next;
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (hit_reg)
                        begin
                            head_reg[k_reg]  <= head_inc;
                            count_reg[k_reg] <= cur_count - 1'b1;
                        end
                    end
                    OP_RELEASE:
                    begin
                        if (hit_reg && push_ok)
                        begin
                            count_reg[k_reg] <= cur_count + 1'b1;
                            if (cur_wmark != CNT_W'(SLOTS))
                            begin
                                wmark_reg[k_reg] <= cur_wmark + 1'b1;
                            end
                        end
                    end
                    OP_ADD_PAGE:
                    begin
                        if (!store_full)
                        begin
                            head_reg[new_pg]  <= '0;
                            count_reg[new_pg] <= CNT_W'(SLOTS);
                            wmark_reg[new_pg] <= '0;
                        end
                    end
                    OP_RELEASE_ALL:
                    begin
                        for (int i = 0; i < MAX_PAGES; i++)
                        begin
                            head_reg[i]  <= '0;
                            count_reg[i] <= '0;
                            wmark_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                        out_valid_reg <= 1'b1;
                    end
                endcase
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, page bases and the slot memory carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= ssa_op_t'(opcode);
            addr_reg <= address;
        end
        if (cmd.read_slot)
        begin
            rdata_reg <= slot_mem[rd_addr];
        end
        if (mem_we)
        begin
            slot_mem[wr_addr] <= quot_reg;
        end
        if (cmd.calc_grant)
        begin
            prod_reg <= PROD_W'(slot_idx) * PROD_W'(SLOT_BYTES);
        end
        // Slot index of a released address: the page offset times a scaled reciprocal
        // of the slot size, exact for every offset inside a page.
        if (cmd.div_start)
        begin
            off_reg <= OFF_W'(offset);
        end
        if (cmd.div_step)
        begin
            quot_reg <= IDX_W'(mul_full >> REC_SH);
        end
        if (cmd.commit)
        begin
            slot_address_reg <= grant_next;
            status_reg       <= status_next;
            refill_reg       <= refill_next;
            free_total_reg   <= (int'(total_next) > 511) ? 9'd511 : 9'(total_next);
            if (op_reg == OP_ADD_PAGE && !store_full)
            begin
                base_reg[new_pg] <= addr_reg;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign slot_address   = slot_address_reg;
    assign status         = status_reg;
    assign refill_request = refill_reg;
    assign free_total     = free_total_reg;

endmodule

// ----- tb/sv/slot_alloc_monitor.sv -----
// Result predictor and comparator for the scratch slot allocator channels.
module slot_alloc_monitor #(
    parameter int SLOT_BYTES = 64,
    parameter int PAGE_BYTES = 4096,
    parameter int MAX_PAGES  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] address,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] slot_address,
    input  logic [1:0]  status,
    input  logic        refill_request,
    input  logic [8:0]  free_total,
    output int          fail_count,
    output int          results_waiting
);
    import ssa_pkg::*;

    localparam int SLOTS_PER_PAGE = PAGE_BYTES / SLOT_BYTES;
    localparam int HALF_PAGE      = SLOTS_PER_PAGE / 2;
    localparam int IDX_W          = $clog2(SLOTS_PER_PAGE);
    localparam int FREE_MAX       = 511;

    typedef struct packed {
        logic [63:0] slot_address;
        ssa_status_t status;
        logic        refill_request;
        logic [8:0]  free_total;
    } slot_result_t;

    logic [63:0]      base_of [MAX_PAGES];
    logic [IDX_W-1:0] free_idx [MAX_PAGES][SLOTS_PER_PAGE];
    logic [IDX_W-1:0] head_of [MAX_PAGES];
    logic [IDX_W:0]   fill_of [MAX_PAGES];
    int               pages_in_use;
    logic             refill_owed;

    slot_result_t     results_due[$];
    slot_result_t     oldest;
    int               fails = 0;

    assign fail_count = fails;

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        fails++;
    endtask

    function automatic int free_slots();
        int total;
        int k;
        total = 0;
        for (k = 0; k < pages_in_use; k++)
            total += fill_of[k];
        return total;
    endfunction

    // Applies one transfer to the shadow allocator and returns its result.
    function automatic slot_result_t apply_slot_op(ssa_op_t op, logic [63:0] addr);
        slot_result_t     r;
        logic [63:0]      offset;
        logic [63:0]      slot;
        logic [IDX_W-1:0] tail;
        logic             found;
        int               k;
        int               total;
        r.slot_address   = '0;
        r.status         = STAT_OK;
        r.refill_request = 1'b0;
        found            = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                r.status = STAT_NO_SLOT;
                // Newest page first.
                for (k = pages_in_use - 1; k >= 0 && !found; k--)
                begin
                    if (fill_of[k] != 0)
                    begin
                        r.slot_address = base_of[k]
                            + 64'(free_idx[k][head_of[k]]) * 64'(SLOT_BYTES);
                        head_of[k] = head_of[k] + 1'b1;
                        fill_of[k] = fill_of[k] - 1'b1;
                        r.status   = STAT_OK;
                        found      = 1'b1;
                        if (free_slots() < HALF_PAGE && !refill_owed)
                        begin
                            r.refill_request = 1'b1;
                            refill_owed      = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                r.status = STAT_NO_PAGE;
                for (k = pages_in_use - 1; k >= 0 && !found; k--)
                begin
                    // The offset wraps modulo 2^64, so a page at the top covers low addresses.
                    offset = addr - base_of[k];
                    if (offset < 64'(SLOTS_PER_PAGE * SLOT_BYTES))
                    begin
                        if (fill_of[k] < SLOTS_PER_PAGE)
                        begin
                            slot = offset / 64'(SLOT_BYTES);
                            tail = head_of[k] + fill_of[k][IDX_W-1:0];
                            free_idx[k][tail] = slot[IDX_W-1:0];
                            fill_of[k] = fill_of[k] + 1'b1;
                        end
                        r.status = STAT_OK;
                        found    = 1'b1;
                    end
                end
            end
            OP_ADD_PAGE:
            begin
                // Even a rejected page answers an outstanding refill.
                refill_owed = 1'b0;
                if (pages_in_use >= MAX_PAGES)
                    r.status = STAT_STORE_FULL;
                else
                begin
                    base_of[pages_in_use] = addr;
                    for (k = 0; k < SLOTS_PER_PAGE; k++)
                        free_idx[pages_in_use][k] = k[IDX_W-1:0];
                    head_of[pages_in_use] = '0;
                    fill_of[pages_in_use] = (IDX_W+1)'(SLOTS_PER_PAGE);
                    pages_in_use++;
                end
            end
            default:
            begin
                for (k = 0; k < MAX_PAGES; k++)
                begin
                    head_of[k] = '0;
                    fill_of[k] = '0;
                end
                pages_in_use = 0;
            end
        endcase
        total = free_slots();
        if (total > FREE_MAX)
            total = FREE_MAX;
        r.free_total = total[8:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_PAGES; k++)
            begin
                head_of[k] = '0;
                fill_of[k] = '0;
            end
            pages_in_use = 0;
            refill_owed  = 1'b0;
            results_due.delete();
            results_waiting <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    flag_mismatch("result with nothing pending", slot_address, '0);
                else
                begin
                    oldest = results_due.pop_front();
                    if (slot_address !== oldest.slot_address)
                        flag_mismatch("slot_address", slot_address, oldest.slot_address);
                    if (status !== oldest.status)
                        flag_mismatch("status", 64'(status), 64'(oldest.status));
                    if (refill_request !== oldest.refill_request)
                        flag_mismatch("refill_request", 64'(refill_request),
                                      64'(oldest.refill_request));
                    if (free_total !== oldest.free_total)
                        flag_mismatch("free_total", 64'(free_total), 64'(oldest.free_total));
                end
            end
            if (in_valid && in_ready)
                results_due.push_back(apply_slot_op(ssa_op_t'(opcode), address));
            results_waiting <= results_due.size();
        end
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the scratch slot allocator testbench: clock, reset, stimulus and verdict.
module testbench;
    import ssa_pkg::*;

    localparam int SLOT_BYTES     = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int MAX_PAGES      = 4;
    localparam int SLOTS_PER_PAGE = PAGE_BYTES / SLOT_BYTES;
    localparam int STALL_LIMIT    = 2000;
    localparam int PHASE_ITEMS    = 150;
    localparam int SETTLE_CYCLES  = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [63:0] address;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] slot_address;
    logic [1:0]  status;
    logic        refill_request;
    logic [8:0]  free_total;

    int          fail_count;
    int          results_waiting;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          items_sent;
    int          quiet_cycles = 0;
    logic [63:0] live_bases[$];

    scratch_slot_allocator_unit #(
        .SLOT_BYTES(SLOT_BYTES),
        .PAGE_BYTES(PAGE_BYTES),
        .MAX_PAGES (MAX_PAGES)
    ) uut (.*);

    slot_alloc_monitor #(
        .SLOT_BYTES(SLOT_BYTES),
        .PAGE_BYTES(PAGE_BYTES),
        .MAX_PAGES (MAX_PAGES)
    ) monitor (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Any transfer on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_item(ssa_op_t op, logic [63:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        address  <= addr;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (results_waiting != 0);
    endtask

    task automatic add_page(logic [63:0] base);
        send_item(OP_ADD_PAGE, base);
        if (live_bases.size() < MAX_PAGES)
            live_bases.push_back(base);
    endtask

    task automatic release_everything();
        send_item(OP_RELEASE_ALL, {$urandom, $urandom});
        live_bases.delete();
    endtask

    function automatic logic [63:0] fresh_base();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return 64'hFFFF_FFFF_FFFF_F000 + 64'($urandom_range(PAGE_BYTES - 1));
        if (pick == 1)
            return {$urandom, $urandom};
        if (pick == 2 && live_bases.size() != 0)
            return live_bases[$urandom_range(live_bases.size() - 1)]
                + 64'($urandom_range(PAGE_BYTES - 1));
        return {$urandom, $urandom} & ~64'(PAGE_BYTES - 1);
    endfunction

    function automatic logic [63:0] slot_in_live_page();
        logic [63:0] base;
        base = live_bases[$urandom_range(live_bases.size() - 1)];
        if ($urandom_range(4) == 0)
            return base + 64'($urandom_range(PAGE_BYTES - 1));
        return base + 64'($urandom_range(SLOTS_PER_PAGE - 1)) * 64'(SLOT_BYTES);
    endfunction

    // Episodes: usually a clean start, a few pages, then a run heavy on allocs
    // so that pages drain, refills get asked for and allocs run dry.
    task automatic run_random(int count);
        int stop_at;
        int burst;
        int pick;
        int pages;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(9) < 7)
                release_everything();
            pick  = $urandom_range(19);
            pages = (pick < 12) ? 1 : (pick < 17) ? 2 : (pick < 19) ? 4 : 5;
            repeat (pages)
                add_page(fresh_base());
            burst = $urandom_range(20, 110);
            while (burst > 0 && items_sent < stop_at)
            begin
                pick = $urandom_range(99);
                if (pick < 68)
                    send_item(OP_ALLOC, {$urandom, $urandom});
                else if (pick < 86 && live_bases.size() != 0)
                    send_item(OP_RELEASE, slot_in_live_page());
                else if (pick < 94)
                    send_item(OP_RELEASE, {$urandom, $urandom});
                else if (pick < 98)
                    add_page(fresh_base());
                else
                    release_everything();
                burst--;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_ALLOC;
        address       = '0;
        items_sent    = 0;
        send_idle_pct = 37;
        recv_idle_pct = 82;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_ALLOC, '1);
        send_item(OP_RELEASE, '0);
        add_page(64'h0);
        send_item(OP_ALLOC, 64'h0);
        // This page wraps past the top of the address space.
        add_page(64'hFFFF_FFFF_FFFF_F800);
        send_item(OP_ALLOC, {$urandom, $urandom});
        send_item(OP_RELEASE, 64'h10);
        send_item(OP_RELEASE, '1);
        // Overlaps the first page; its FIFO is full, so the push is dropped.
        add_page(64'h800);
        send_item(OP_RELEASE, 64'hC00);
        send_item(OP_RELEASE, 64'h40);
        send_item(OP_RELEASE, 64'h40);
        add_page('1);
        add_page(64'h5555_5555_5555_5555);
        send_item(OP_RELEASE, 64'h8000_0000_0000_0000);
        send_item(OP_RELEASE, 64'h7FFF_FFFF_FFFF_FFFF);
        release_everything();
        send_item(OP_ALLOC, {$urandom, $urandom});
        add_page(64'hAAAA_AAAA_AAAA_A000);
        send_item(OP_ALLOC, '0);

        run_random(PHASE_ITEMS);
        wait_all_results();
        send_idle_pct = 82;
        recv_idle_pct = 37;
        run_random(PHASE_ITEMS);
        wait_all_results();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(PHASE_ITEMS);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && results_waiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
